// ===== design/axis_homing_and_positioning_fsm_top_assert.svh =====
// assertion macros for the homing sequencer checker
// expects signals named clock and reset in the including scope
`ifndef AXIS_HOMING_AND_POSITIONING_FSM_TOP_ASSERT_SVH
`define AXIS_HOMING_AND_POSITIONING_FSM_TOP_ASSERT_SVH

// plain clocked property, off during reset
`define AHP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property that must hold whenever a condition is seen
`define AHP_ASSERT_WHEN(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`endif

// ===== design/ahp_pkg.sv =====
// shared types and constants for the axis homing and positioning sequencer
// no dependencies
`default_nettype none

package ahp_pkg;

   localparam int POS_W            = 24;
   localparam int DRV_W            = 24;
   localparam int SPD_W            = 16;
   localparam int PHASE_W          = 3;
   localparam int KIND_W           = 2;
   localparam int CSR_IDX_W        = 2;
   localparam int POS_BITS_DEFAULT = 24;

   localparam logic [SPD_W-1:0] DOWN_SPEED_RST = 16'hC000;
   localparam logic [SPD_W-1:0] UP_SPEED_RST   = 16'h4000;
   localparam logic [SPD_W-1:0] TURN_TICKS_RST = 16'd100;
   localparam logic [SPD_W-1:0] TOLERANCE_RST  = 16'd10;

   typedef enum logic [PHASE_W-1:0] {
      PH_START   = 3'd0,
      PH_DOWN    = 3'd1,
      PH_UP      = 3'd2,
      PH_TURN    = 3'd3,
      PH_READY   = 3'd4,
      PH_ANGLING = 3'd5,
      PH_MANUAL  = 3'd6
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_TARGET = 2'd1,
      KIND_MANUAL = 2'd2,
      KIND_RESET  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DOWN_SPEED = 2'd0,
      CSR_UP_SPEED   = 2'd1,
      CSR_TURN_TICKS = 2'd2,
      CSR_TOLERANCE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      kind_type         kind;
      logic             home_switch;
      logic             up_limit;
      logic             down_limit;
      logic [POS_W-1:0] position;
      logic [POS_W-1:0] target_position;
      logic [SPD_W-1:0] manual_drive;
   } item_type;

   typedef struct packed {
      logic [DRV_W-1:0] drive_value;
      logic             drive_is_position;
      phase_type        phase;
      logic             ready_res;
   } result_type;

   typedef struct packed {
      logic             valid;
      csr_index_type    index;
      logic [SPD_W-1:0] data;
   } csr_write_type;

endpackage

`default_nettype wire

// ===== design/axis_homing_and_positioning_fsm_top.sv =====
// top level of the axis homing and positioning sequencer
// depends on ahp_pkg, ahp_in_stage, ahp_core, ahp_out_reg
//
// usage:
//   req_* carries one item per transfer: a control tick with switch inputs
//   and encoder position, a set-target command, a manual-drive command or a
//   reset command. every item gives exactly one result on rsp_*, showing the
//   drive, drive mode and phase after that item.
//   csr_* writes one of four settings (down speed, up speed, turnaround
//   ticks, tolerance); csr_ready is always high. write only while idle.
//   results: an item passes through the input register, then the core and
//   the result register, before its result is valid on rsp_*.
//   rate: one item per cycle while the receiver takes results; the input
//   register feeds the core and result register in one pass, no extra stage.
//   when the receiver stalls, the result register holds its result, the
//   input register holds the next item, and req_ready drops once both are
//   full; nothing is lost or repeated.
//   reset (synchronous) clears both registers, puts the axis in the start
//   phase in position mode with zero drive, and restores setting defaults.
`default_nettype none

module axis_homing_and_positioning_fsm_top
   import ahp_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [KIND_W-1:0]      req_kind,
   input  wire logic                   req_home_switch,
   input  wire logic                   req_up_limit,
   input  wire logic                   req_down_limit,
   input  wire logic signed [POS_W-1:0] req_position,
   input  wire logic signed [POS_W-1:0] req_target_position,
   input  wire logic signed [SPD_W-1:0] req_manual_drive,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [DRV_W-1:0]     rsp_drive_value,
   output logic                        rsp_drive_is_position,
   output logic [PHASE_W-1:0]          rsp_phase,
   output logic                        rsp_ready_res,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [SPD_W-1:0]       csr_wdata
);

   item_type      req_item;
   item_type      s1_item;
   logic          s1_valid;
   logic          out_free;
   logic          step_en;
   csr_write_type csr_wr;
   result_type    core_result;
   result_type    rsp_result;

   assign req_item.kind            = kind_type'(req_kind);
   assign req_item.home_switch     = req_home_switch;
   assign req_item.up_limit        = req_up_limit;
   assign req_item.down_limit      = req_down_limit;
   assign req_item.position        = req_position;
   assign req_item.target_position = req_target_position;
   assign req_item.manual_drive    = req_manual_drive;

   assign csr_ready    = 1'b1;
   assign csr_wr.valid = csr_valid;
   assign csr_wr.index = csr_index_type'(csr_index);
   assign csr_wr.data  = csr_wdata;

   assign step_en = s1_valid && out_free;

   ahp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_item),
      .take      (step_en),
      .out_valid (s1_valid),
      .out_item  (s1_item)
   );

   ahp_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (s1_item),
      .csr     (csr_wr),
      .result  (core_result)
   );

   ahp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en),
      .in_result  (core_result),
      .free       (out_free),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   assign rsp_drive_value       = rsp_result.drive_value;
   assign rsp_drive_is_position = rsp_result.drive_is_position;
   assign rsp_phase             = rsp_result.phase;
   assign rsp_ready_res         = rsp_result.ready_res;

endmodule

`default_nettype wire

// ===== design/ahp_in_stage.sv =====
// input register of the sequencer: holds one accepted item until the core takes it
// depends on ahp_pkg
`default_nettype none

module ahp_in_stage
   import ahp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire item_type in_item,
   input  wire logic     take,
   output logic          out_valid,
   output item_type      out_item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign in_ready  = !valid_ff || take;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/ahp_core.sv =====
// sequencer core: settings registers, phase state machine and result logic
// depends on ahp_pkg
`default_nettype none

module ahp_core
   import ahp_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire item_type      item,
   input  wire csr_write_type csr,
   output result_type        result
);

   localparam int EXT_W = ((POS_BITS > POS_W) ? POS_BITS : POS_W) + 1;
   localparam int ERR_W = POS_BITS + 1;
   localparam int CMP_W = (ERR_W > SPD_W) ? ERR_W : SPD_W;
   localparam logic signed [EXT_W-1:0] CLAMP_HI =
      EXT_W'((longint'(1) <<< (POS_BITS - 1)) - longint'(1));
   localparam logic signed [EXT_W-1:0] CLAMP_LO =
      EXT_W'(-(longint'(1) <<< (POS_BITS - 1)));

   // saturate a port-width position to the internal position width
   function automatic logic signed [POS_BITS-1:0] clamp_pos(input logic [POS_W-1:0] v);
      logic signed [EXT_W-1:0] wide;
      wide = EXT_W'($signed(v));
      if (wide > CLAMP_HI) begin
         return CLAMP_HI[POS_BITS-1:0];
      end else if (wide < CLAMP_LO) begin
         return CLAMP_LO[POS_BITS-1:0];
      end else begin
         return wide[POS_BITS-1:0];
      end
   endfunction

   // settings
   logic [SPD_W-1:0] down_speed_ff;
   logic [SPD_W-1:0] up_speed_ff;
   logic [SPD_W-1:0] turn_ticks_ff;
   logic [SPD_W-1:0] tolerance_ff;

   // sequencer state
   phase_type                   phase_ff, phase_in;
   logic [SPD_W-1:0]            wait_ff, wait_in;
   logic signed [POS_BITS-1:0]  target_ff, target_in;
   logic                        pos_mode_ff, pos_mode_in;
   logic [DRV_W-1:0]            drive_ff, drive_in;

   logic signed [POS_BITS-1:0] pos_clamped;
   logic signed [POS_BITS-1:0] tgt_clamped;
   logic signed [ERR_W-1:0]    err;
   logic [ERR_W-1:0]           err_mag;
   logic                       reached;
   logic [SPD_W-1:0]           wait_inc;
   logic                       turn_done;
   logic signed [EXT_W-1:0]    target_wide;
   logic [DRV_W-1:0]           target_drive;
   logic [DRV_W-1:0]           down_drive;
   logic [DRV_W-1:0]           up_drive;
   logic [DRV_W-1:0]           manual_drive;

   always_ff @(posedge clock) begin
      if (reset) begin
         down_speed_ff <= DOWN_SPEED_RST;
         up_speed_ff   <= UP_SPEED_RST;
         turn_ticks_ff <= TURN_TICKS_RST;
         tolerance_ff  <= TOLERANCE_RST;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_DOWN_SPEED: down_speed_ff <= csr.data;
            CSR_UP_SPEED:   up_speed_ff   <= csr.data;
            CSR_TURN_TICKS: turn_ticks_ff <= csr.data;
            CSR_TOLERANCE:  tolerance_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // datapath pieces used by the phase logic
   assign pos_clamped  = clamp_pos(item.position);
   assign tgt_clamped  = clamp_pos(item.target_position);
   assign err          = ERR_W'(target_ff) - ERR_W'(pos_clamped);
   assign err_mag      = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
   assign reached      = pos_mode_ff && (CMP_W'(err_mag) < CMP_W'(tolerance_ff));
   assign wait_inc     = (wait_ff == '1) ? wait_ff : wait_ff + SPD_W'(1);
   assign turn_done    = wait_inc >= turn_ticks_ff;
   assign target_wide  = EXT_W'(target_ff);
   assign target_drive = target_wide[DRV_W-1:0];
   assign down_drive   = DRV_W'($signed(down_speed_ff));
   assign up_drive     = DRV_W'($signed(up_speed_ff));
   assign manual_drive = DRV_W'($signed(item.manual_drive));

   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      target_in   = target_ff;
      pos_mode_in = pos_mode_ff;
      drive_in    = drive_ff;
      unique case (item.kind)
         KIND_TICK: begin
            unique case (phase_ff)
               PH_START: begin
                  pos_mode_in = 1'b0;
                  wait_in     = '0;
                  phase_in    = PH_TURN;
               end
               PH_DOWN: begin
                  drive_in = down_drive;
                  priority if (item.home_switch) begin
                     wait_in  = '0;
                     phase_in = PH_TURN;
                  end else if (item.down_limit) begin
                     phase_in = PH_UP;
                  end
               end
               PH_UP: begin
                  drive_in = up_drive;
                  priority if (item.home_switch) begin
                     drive_in    = '0;
                     pos_mode_in = 1'b1;
                     phase_in    = PH_READY;
                  end else if (item.up_limit) begin
                     phase_in = PH_DOWN;
                  end
               end
               PH_TURN: begin
                  drive_in = down_drive;
                  wait_in  = wait_inc;
                  // timeout wins over the limit switches
                  priority if (turn_done) begin
                     phase_in = PH_UP;
                  end else if (item.up_limit) begin
                     phase_in = PH_DOWN;
                  end else if (item.down_limit) begin
                     phase_in = PH_UP;
                  end
               end
               PH_ANGLING: begin
                  drive_in = target_drive;
                  if (item.up_limit || item.down_limit || reached) begin
                     phase_in = PH_READY;
                  end
               end
               default: ;
            endcase
         end
         KIND_TARGET: begin
            if (phase_ff == PH_READY) begin
               target_in = tgt_clamped;
               phase_in  = PH_ANGLING;
            end
         end
         KIND_MANUAL: begin
            phase_in    = PH_MANUAL;
            pos_mode_in = 1'b0;
            drive_in    = manual_drive;
         end
         KIND_RESET: begin
            phase_in    = PH_START;
            pos_mode_in = 1'b1;
            drive_in    = '0;
         end
         default: ;
      endcase

      result.drive_value       = drive_in;
      result.drive_is_position = pos_mode_in;
      result.phase             = phase_in;
      result.ready_res         = (phase_in == PH_READY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         wait_ff     <= '0;
         target_ff   <= '0;
         pos_mode_ff <= 1'b1;
         drive_ff    <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         wait_ff     <= wait_in;
         target_ff   <= target_in;
         pos_mode_ff <= pos_mode_in;
         drive_ff    <= drive_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ahp_out_reg.sv =====
// result register: holds one result until the receiver takes it
// depends on ahp_pkg
`default_nettype none

module ahp_out_reg
   import ahp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type in_result,
   output logic            free,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // a new result may enter in the same cycle the old one is transferred
   assign free       = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      priority if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= in_result;
      end
   end

endmodule

`default_nettype wire

// ===== design/ahp_checker.sv =====
// port-level checker for the homing sequencer, bound to the top level
// depends on ahp_pkg and axis_homing_and_positioning_fsm_top_assert.svh
`default_nettype none
`include "axis_homing_and_positioning_fsm_top_assert.svh"

module ahp_checker
   import ahp_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [DRV_W-1:0]     rsp_drive_value,
   input wire logic                 rsp_drive_is_position,
   input wire logic [PHASE_W-1:0]   rsp_phase,
   input wire logic                 rsp_ready_res
);

   logic                       ready_phase;
   logic                       pos_phase;
   logic                       volt_phase;
   logic                       rsp_stall;
   logic [DRV_W+PHASE_W+1:0]   rsp_bits;

   assign ready_phase = (rsp_phase == PH_READY);
   assign pos_phase   = rsp_valid && (rsp_phase == PH_READY || rsp_phase == PH_ANGLING);
   assign volt_phase  = rsp_valid && (rsp_phase == PH_DOWN || rsp_phase == PH_UP ||
                                      rsp_phase == PH_TURN || rsp_phase == PH_MANUAL);
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_bits    = {rsp_drive_value, rsp_drive_is_position, rsp_phase, rsp_ready_res};

   // ready flag and phase must agree
   `AHP_ASSERT_WHEN(a_ready_flag, rsp_valid, rsp_ready_res == ready_phase, "ready_res mismatch")

   // ready and angling are only reached after homing, in position mode
   `AHP_ASSERT_WHEN(a_pos_mode, pos_phase, rsp_drive_is_position, "position mode lost")

   // homing moves and manual drive run in voltage mode
   `AHP_ASSERT_WHEN(a_volt_mode, volt_phase, !rsp_drive_is_position, "unexpected position mode")

   // a stalled result is held until its transfer
   `AHP_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_valid && $stable(rsp_bits)), "result not held")

endmodule

bind axis_homing_and_positioning_fsm_top ahp_checker u_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_drive_value       (rsp_drive_value),
   .rsp_drive_is_position (rsp_drive_is_position),
   .rsp_phase             (rsp_phase),
   .rsp_ready_res         (rsp_ready_res)
);

`default_nettype wire

// ===== dv/axis_homing_and_positioning_fsm_top_tb.sv =====
// testbench for the axis homing and positioning sequencer: a directed table, then
// random items over several register settings, checked against an in-bench phase model
// depends on ahp_pkg and axis_homing_and_positioning_fsm_top
`timescale 1ns / 100ps

module axis_homing_and_positioning_fsm_top_tb;
   import ahp_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 241;
   localparam int HOLD_CYCLES   = 60;
   localparam int POS_MAX       = 8388607;
   localparam int POS_MIN       = -8388608;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type want;
   } plan_row_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [KIND_W-1:0]        req_kind;
   logic                     req_home_switch;
   logic                     req_up_limit;
   logic                     req_down_limit;
   logic signed [POS_W-1:0]  req_position;
   logic signed [POS_W-1:0]  req_target_position;
   logic signed [SPD_W-1:0]  req_manual_drive;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DRV_W-1:0]  rsp_drive_value;
   logic                     rsp_drive_is_position;
   logic [PHASE_W-1:0]       rsp_phase;
   logic                     rsp_ready_res;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [SPD_W-1:0]         csr_wdata;

   // model of the axis state and settings
   phase_type                ax_phase;
   logic [15:0]              turn_count;
   logic signed [POS_W-1:0]  tgt_hold;
   logic                     pos_mode;
   logic signed [DRV_W-1:0]  drv_hold;
   logic [SPD_W-1:0]         cfg_down;
   logic [SPD_W-1:0]         cfg_up;
   logic [SPD_W-1:0]         cfg_turn;
   logic [SPD_W-1:0]         cfg_tol;

   result_type               results_due[$];
   plan_row_type             axis_plan[$];
   result_type               oldest;
   int                       fail_count = 0;
   int                       items_sent = 0;
   int                       results_seen = 0;
   int                       cycle_count = 0;
   int                       snd_idle = 0;
   int                       rcv_stall = 0;
   int                       hold_left = 0;
   bit [7:0]                 phases_seen = '0;

   axis_homing_and_positioning_fsm_top dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_kind              (req_kind),
      .req_home_switch       (req_home_switch),
      .req_up_limit          (req_up_limit),
      .req_down_limit        (req_down_limit),
      .req_position          (req_position),
      .req_target_position   (req_target_position),
      .req_manual_drive      (req_manual_drive),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive_value       (rsp_drive_value),
      .rsp_drive_is_position (rsp_drive_is_position),
      .rsp_phase             (rsp_phase),
      .rsp_ready_res         (rsp_ready_res),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  results_due.size());
         $display("FAIL");
         $finish;
      end
   end

   // advance the axis by one item and return the result it shows
   function automatic result_type step_axis(item_type it);
      result_type r;
      int         err;
      case (it.kind)
         KIND_TICK: begin
            case (ax_phase)
               PH_START: begin
                  pos_mode   = 1'b0;
                  turn_count = '0;
                  ax_phase   = PH_TURN;
               end
               PH_DOWN: begin
                  drv_hold = {{8{cfg_down[15]}}, cfg_down};
                  if (it.home_switch) begin
                     turn_count = '0;
                     ax_phase   = PH_TURN;
                  end else if (it.down_limit) begin
                     ax_phase = PH_UP;
                  end
               end
               PH_UP: begin
                  drv_hold = {{8{cfg_up[15]}}, cfg_up};
                  if (it.home_switch) begin
                     drv_hold = '0;
                     pos_mode = 1'b1;
                     ax_phase = PH_READY;
                  end else if (it.up_limit) begin
                     ax_phase = PH_DOWN;
                  end
               end
               PH_TURN: begin
                  drv_hold = {{8{cfg_down[15]}}, cfg_down};
                  if (turn_count != 16'hFFFF) turn_count = turn_count + 16'd1;
                  // elapsed time outranks the limit switches
                  if (turn_count >= cfg_turn) ax_phase = PH_UP;
                  else if (it.up_limit) ax_phase = PH_DOWN;
                  else if (it.down_limit) ax_phase = PH_UP;
               end
               PH_ANGLING: begin
                  drv_hold = tgt_hold;
                  if (it.up_limit || it.down_limit) ax_phase = PH_READY;
                  if (pos_mode) begin
                     err = int'(tgt_hold) - int'($signed(it.position));
                     if (err < 0) err = -err;
                     if (err < int'(cfg_tol)) ax_phase = PH_READY;
                  end
               end
               default: ;
            endcase
         end
         KIND_TARGET: begin
            if (ax_phase == PH_READY) begin
               tgt_hold = it.target_position;
               ax_phase = PH_ANGLING;
            end
         end
         KIND_MANUAL: begin
            ax_phase = PH_MANUAL;
            pos_mode = 1'b0;
            drv_hold = {{8{it.manual_drive[15]}}, it.manual_drive};
         end
         default: begin
            ax_phase = PH_START;
            pos_mode = 1'b1;
            drv_hold = '0;
         end
      endcase
      r.drive_value       = drv_hold;
      r.drive_is_position = pos_mode;
      r.phase             = ax_phase;
      r.ready_res         = (ax_phase == PH_READY);
      return r;
   endfunction

   function automatic void add_row(kind_type k, bit home, bit upl, bit dnl, int pos,
                                   int tgt, int man, bit typed, logic [DRV_W-1:0] drv,
                                   bit in_pos, phase_type ph);
      plan_row_type row;
      row.it.kind                 = k;
      row.it.home_switch          = home;
      row.it.up_limit             = upl;
      row.it.down_limit           = dnl;
      row.it.position             = pos[POS_W-1:0];
      row.it.target_position      = tgt[POS_W-1:0];
      row.it.manual_drive         = man[SPD_W-1:0];
      row.typed                   = typed;
      row.want.drive_value        = drv;
      row.want.drive_is_position  = in_pos;
      row.want.phase              = ph;
      row.want.ready_res          = (ph == PH_READY);
      axis_plan.push_back(row);
   endfunction

   // random item shaped by the current phase so homing and angling get exercised
   function automatic item_type pick_axis_item();
      item_type it;
      int       roll;
      int       span;
      int       near;
      it.position        = POS_W'($urandom);
      it.target_position = POS_W'($urandom);
      it.manual_drive    = SPD_W'($urandom);
      roll = $urandom_range(99);
      if (ax_phase == PH_MANUAL)
         it.kind = roll < 35 ? KIND_RESET : roll < 45 ? KIND_MANUAL :
                   roll < 55 ? KIND_TARGET : KIND_TICK;
      else if (ax_phase == PH_READY)
         it.kind = roll < 50 ? KIND_TARGET : roll < 53 ? KIND_MANUAL :
                   roll < 56 ? KIND_RESET : KIND_TICK;
      else
         it.kind = roll < 3 ? KIND_MANUAL : roll < 5 ? KIND_RESET :
                   roll < 9 ? KIND_TARGET : KIND_TICK;
      if ($urandom_range(1) == 0)
         it.target_position = POS_W'(int'($urandom_range(10000)) - 5000);
      it.home_switch = $urandom_range(99) <
                       ((ax_phase == PH_DOWN || ax_phase == PH_UP) ? 15 : 5);
      it.up_limit    = $urandom_range(99) < 8;
      it.down_limit  = $urandom_range(99) < 8;
      if (ax_phase == PH_ANGLING && $urandom_range(99) < 60) begin
         span = (cfg_tol > 16'd2000) ? 4000 : 2 * int'(cfg_tol) + 4;
         near = int'(tgt_hold) + int'($urandom_range(2 * span)) - span;
         if (near > POS_MAX) near = POS_MAX;
         if (near < POS_MIN) near = POS_MIN;
         it.position = near[POS_W-1:0];
      end
      return it;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input item_type it, input bit typed, input result_type want);
      result_type got;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= it.kind;
      req_home_switch     <= it.home_switch;
      req_up_limit        <= it.up_limit;
      req_down_limit      <= it.down_limit;
      req_position        <= it.position;
      req_target_position <= it.target_position;
      req_manual_drive    <= it.manual_drive;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = step_axis(it);
      results_due.push_back(typed ? want : got);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [SPD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DOWN_SPEED: cfg_down = data;
         CSR_UP_SPEED:   cfg_up   = data;
         CSR_TURN_TICKS: cfg_turn = data;
         CSR_TOLERANCE:  cfg_tol  = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic csr_program(input logic [SPD_W-1:0] dn, input logic [SPD_W-1:0] up,
                              input logic [SPD_W-1:0] turn, input logic [SPD_W-1:0] tol);
      csr_write(CSR_DOWN_SPEED, dn);
      csr_write(CSR_UP_SPEED, up);
      csr_write(CSR_TURN_TICKS, turn);
      csr_write(CSR_TOLERANCE, tol);
      csr_valid <= 1'b0;
   endtask

   // entered at a falling edge with the last item already transferred
   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_stall);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         phases_seen[rsp_phase] = 1'b1;
         if (results_due.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            oldest = results_due.pop_front();
            if (rsp_drive_value !== oldest.drive_value) begin
               $error("drive_value: expected %06h, got %06h", oldest.drive_value,
                      rsp_drive_value);
               fail_count++;
            end
            if (rsp_drive_is_position !== oldest.drive_is_position) begin
               $error("drive_is_position: expected %0d, got %0d",
                      oldest.drive_is_position, rsp_drive_is_position);
               fail_count++;
            end
            if (rsp_phase !== oldest.phase) begin
               $error("phase: expected %0d, got %0d", oldest.phase, rsp_phase);
               fail_count++;
            end
            if (rsp_ready_res !== oldest.ready_res) begin
               $error("ready_res: expected %0d, got %0d", oldest.ready_res, rsp_ready_res);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_kind            = KIND_TICK;
      req_home_switch     = 1'b0;
      req_up_limit        = 1'b0;
      req_down_limit      = 1'b0;
      req_position        = '0;
      req_target_position = '0;
      req_manual_drive    = '0;
      csr_valid           = 1'b0;
      csr_index           = CSR_DOWN_SPEED;
      csr_wdata           = '0;
      ax_phase            = PH_START;
      turn_count          = '0;
      tgt_hold            = '0;
      pos_mode            = 1'b1;
      drv_hold            = '0;
      cfg_down            = DOWN_SPEED_RST;
      cfg_up              = UP_SPEED_RST;
      cfg_turn            = TURN_TICKS_RST;
      cfg_tol             = TOLERANCE_RST;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // homing through every switch case with the reset settings
      add_row(KIND_TICK, 0, 0, 0, 0, 0, 0, 1, 24'h000000, 0, PH_TURN);
      add_row(KIND_TICK, 0, 1, 0, 0, 0, 0, 1, 24'hFFC000, 0, PH_DOWN);
      add_row(KIND_TICK, 0, 1, 1, 0, 0, 0, 1, 24'hFFC000, 0, PH_UP);
      add_row(KIND_TICK, 0, 0, 1, 0, 0, 0, 1, 24'h004000, 0, PH_UP);
      add_row(KIND_TICK, 0, 1, 0, 0, 0, 0, 1, 24'h004000, 0, PH_DOWN);
      add_row(KIND_TICK, 1, 0, 1, 0, 0, 0, 1, 24'hFFC000, 0, PH_TURN);
      add_row(KIND_TICK, 0, 0, 1, 0, 0, 0, 1, 24'hFFC000, 0, PH_UP);
      add_row(KIND_TICK, 1, 1, 0, 0, 0, 0, 1, 24'h000000, 1, PH_READY);
      add_row(KIND_TICK, 1, 1, 1, POS_MAX, 0, 0, 1, 24'h000000, 1, PH_READY);
      // angling: error equal to tolerance keeps going, one less arrives
      add_row(KIND_TARGET, 0, 0, 0, 0, 1000, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TICK, 0, 0, 0, 990, 0, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TICK, 0, 0, 0, 1009, 0, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TARGET, 0, 0, 0, 0, POS_MAX, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TICK, 0, 0, 0, POS_MIN, 0, 0, 1, 24'h7FFFFF, 1, PH_ANGLING);
      add_row(KIND_TARGET, 0, 0, 0, 0, 5, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TICK, 0, 1, 0, 0, 0, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TARGET, 0, 0, 0, 0, POS_MIN, 0, 0, 24'h0, 0, PH_START);
      add_row(KIND_TICK, 0, 0, 1, POS_MAX, 0, 0, 1, 24'h800000, 1, PH_READY);
      // manual holds until a reset command
      add_row(KIND_MANUAL, 0, 0, 0, 0, 0, -32768, 1, 24'hFF8000, 0, PH_MANUAL);
      add_row(KIND_TICK, 1, 0, 0, 0, 0, 0, 1, 24'hFF8000, 0, PH_MANUAL);
      add_row(KIND_MANUAL, 0, 0, 0, 0, 0, 32767, 1, 24'h007FFF, 0, PH_MANUAL);
      add_row(KIND_RESET, 0, 0, 0, 0, 0, 0, 1, 24'h000000, 1, PH_START);
      add_row(KIND_TICK, 0, 0, 0, 0, 0, 0, 1, 24'h000000, 0, PH_TURN);
      foreach (axis_plan[i]) send_item(axis_plan[i].it, axis_plan[i].typed, axis_plan[i].want);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results(4);
         case (p)
            0: csr_program(16'h8000, 16'h7FFF, 16'd0, 16'd0);
            1: csr_program(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
            4: csr_program(SPD_W'($urandom), SPD_W'($urandom), SPD_W'($urandom),
                           SPD_W'($urandom_range(3000)));
            default: csr_program(SPD_W'($urandom), SPD_W'($urandom),
                                 SPD_W'($urandom_range(12)), SPD_W'($urandom_range(3000)));
         endcase
         case (p % 4)
            0: begin snd_idle = 0;  rcv_stall = 0;  end
            1: begin snd_idle = 59; rcv_stall = 0;  end
            2: begin snd_idle = 0;  rcv_stall = 59; end
            default: begin snd_idle = 19; rcv_stall = 19; end
         endcase
         // long receiver hold-off so the block backs up into its input
         if (p == 2) hold_left = HOLD_CYCLES;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 5 && k == PHASE_ITEMS / 2) drain_results(0);
            send_item(pick_axis_item(), 1'b0, '0);
         end
      end
      drain_results(10);

      $display("sent %0d items and checked %0d results over %0d register settings",
               items_sent, results_seen, RANDOM_PHASES + 1);
      $display("result phases seen (bit per phase): %b, failures: %0d", phases_seen,
               fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
